[hw/rtl/lax_wendroff_advection_stencil_defines.svh]
// assertion macros shared by the lax-wendroff stencil rtl
// expects clock and reset to be visible in the module that uses them
`ifndef LAX_WENDROFF_ADVECTION_STENCIL_DEFINES_SVH
`define LAX_WENDROFF_ADVECTION_STENCIL_DEFINES_SVH

// consequent checked in the same cycle
`define LWA_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define LWA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/lwa_pkg.sv]
// types and constants of the lax-wendroff advection stencil
// used by every module of the block except lwa_ram, no dependencies
`default_nettype none

package lwa_pkg;

   localparam int MAX_POINTS = 1024;
   localparam int SAMPLE_W   = 16;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   // wide enough for the point count plus the two wrap reads
   localparam int PT_W       = $clog2(MAX_POINTS + 2);
   localparam int MIN_POINTS = 3;

   localparam int OPCODE_W   = 2;
   localparam int POINT_W    = 10;
   localparam int STEPS_W    = 16;
   localparam int COEF_W     = 16;
   localparam int GCFG_W     = 11;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_W      = 48;
   localparam int RSP_W      = 24;

   typedef enum logic [OPCODE_W-1:0] {
      OP_LOAD = 2'd0,
      OP_RUN  = 2'd1,
      OP_READ = 2'd2
   } opcode_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_GRID_POINTS     = 2'd0,
      CSR_HALF_COURANT    = 2'd1,
      CSR_HALF_COURANT_SQ = 2'd2
   } csr_index_type;

   localparam logic STATUS_DONE  = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD_DATA,
      ST_RUN_RD,
      ST_RUN_DRAIN,
      ST_RESP
   } ctrl_state_type;

   // ctrl to step unit
   typedef struct packed {
      logic start;
      logic issue;
   } step_ctl_type;

   // step unit write into the next-step bank
   typedef struct packed {
      logic                       we;
      logic [IDX_W-1:0]           addr;
      logic signed [SAMPLE_W-1:0] data;
   } step_wr_type;

   // ctrl access to the current bank
   typedef struct packed {
      logic                       rd_en;
      logic [IDX_W-1:0]           rd_addr;
      logic                       wr_en;
      logic [IDX_W-1:0]           wr_addr;
      logic signed [SAMPLE_W-1:0] wr_data;
   } mem_req_type;

endpackage

`default_nettype wire

[hw/rtl/lwa_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module lwa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

[hw/rtl/lwa_step_unit.sv]
// stencil pipeline: three-sample window, differences, products, round and saturate
// depends on lwa_pkg and the assertion macro header
`default_nettype none
`include "lax_wendroff_advection_stencil_defines.svh"

module lwa_step_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire lwa_pkg::step_ctl_type               ctl,
   input  wire logic signed [lwa_pkg::SAMPLE_W-1:0] rdata,
   input  wire logic [lwa_pkg::COEF_W-1:0]          half_courant,
   input  wire logic [lwa_pkg::COEF_W-1:0]          half_courant_sq,
   output      lwa_pkg::step_wr_type                wr,
   output      logic                                busy
);

   localparam int SW    = lwa_pkg::SAMPLE_W;
   localparam int CW    = lwa_pkg::COEF_W;
   localparam int D1_W  = SW + 1;
   localparam int D2_W  = SW + 2;
   localparam int P1_W  = CW + 1 + D1_W;
   localparam int P2_W  = CW + 1 + D2_W;
   localparam int R1_W  = P1_W - CW;
   localparam int R2_W  = P2_W - CW;
   localparam int SUM_W = R2_W + 2;
   localparam logic signed [P1_W-1:0]  RND1 = P1_W'(1) << (CW - 1);
   localparam logic signed [P2_W-1:0]  RND2 = P2_W'(1) << (CW - 1);
   localparam logic signed [SUM_W-1:0] SMAX = SUM_W'((1 << (SW - 1)) - 1);
   localparam logic signed [SUM_W-1:0] SMIN = -SMAX - SUM_W'(1);

   logic                      issue_d_ff;
   logic [1:0]                fill_ff, fill_in;
   logic signed [SW-1:0]      w0_ff, w1_ff, w2_ff;
   logic                      win_valid_ff, win_valid_in;
   logic signed [D1_W-1:0]    d1_ff, d1_in;
   logic signed [D2_W-1:0]    d2_ff, d2_in;
   logic signed [SW-1:0]      uc_d_ff, uc_m_ff;
   logic                      dv_ff, mv_ff;
   logic signed [CW:0]        h_s, g_s;
   logic signed [P1_W-1:0]    p1_ff, p1_in, p1_rnd;
   logic signed [P2_W-1:0]    p2_ff, p2_in, p2_rnd;
   logic signed [R1_W-1:0]    r1;
   logic signed [R2_W-1:0]    r2;
   logic signed [SUM_W-1:0]   sum;
   logic signed [SW-1:0]      wr_data_ff, wr_data_in;
   logic                      wr_we_ff;
   logic [lwa_pkg::IDX_W-1:0] pt_ff, pt_in;

   always_comb begin
      fill_in = fill_ff;
      if (ctl.start) begin
         fill_in = 2'd0;
      end else if (issue_d_ff && fill_ff != 2'd2) begin
         fill_in = fill_ff + 2'd1;
      end
      // third sample in a row completes the window
      win_valid_in = issue_d_ff && fill_ff == 2'd2 && !ctl.start;

      d1_in = D1_W'(w2_ff) - D1_W'(w0_ff);
      d2_in = D2_W'(w2_ff) - (D2_W'(w1_ff) <<< 1) + D2_W'(w0_ff);

      h_s   = $signed({1'b0, half_courant});
      g_s   = $signed({1'b0, half_courant_sq});
      p1_in = P1_W'(d1_ff) * P1_W'(h_s);
      p2_in = P2_W'(d2_ff) * P2_W'(g_s);

      // round to nearest, ties toward plus infinity
      p1_rnd = p1_ff + RND1;
      p2_rnd = p2_ff + RND2;
      r1     = p1_rnd[P1_W-1:CW];
      r2     = p2_rnd[P2_W-1:CW];
      sum    = SUM_W'(uc_m_ff) - SUM_W'(r1) + SUM_W'(r2);
      if (sum > SMAX) begin
         wr_data_in = SW'(SMAX);
      end else if (sum < SMIN) begin
         wr_data_in = SW'(SMIN);
      end else begin
         wr_data_in = SW'(sum);
      end

      pt_in = pt_ff;
      if (ctl.start) begin
         pt_in = '0;
      end else if (wr_we_ff) begin
         pt_in = pt_ff + lwa_pkg::IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_d_ff   <= 1'b0;
         fill_ff      <= 2'd0;
         win_valid_ff <= 1'b0;
         dv_ff        <= 1'b0;
         mv_ff        <= 1'b0;
         wr_we_ff     <= 1'b0;
         pt_ff        <= '0;
      end else begin
         issue_d_ff   <= ctl.issue;
         fill_ff      <= fill_in;
         win_valid_ff <= win_valid_in;
         dv_ff        <= win_valid_ff;
         mv_ff        <= dv_ff;
         wr_we_ff     <= mv_ff;
         pt_ff        <= pt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue_d_ff) begin
         w0_ff <= w1_ff;
         w1_ff <= w2_ff;
         w2_ff <= rdata;
      end
      d1_ff      <= d1_in;
      d2_ff      <= d2_in;
      uc_d_ff    <= w1_ff;
      p1_ff      <= p1_in;
      p2_ff      <= p2_in;
      uc_m_ff    <= uc_d_ff;
      wr_data_ff <= wr_data_in;
   end

   assign wr.we   = wr_we_ff;
   assign wr.addr = pt_ff;
   assign wr.data = wr_data_ff;
   assign busy    = issue_d_ff | win_valid_ff | dv_ff | mv_ff | wr_we_ff;

   // a step begins only on an empty pipeline, and every step begins with start
   `LWA_ASSERT_SAME(a_start_when_empty, ctl.start, !busy, "step start while pipeline busy")
   `LWA_ASSERT_SAME(a_first_issue_starts, ctl.issue && !busy, ctl.start,
                    "step reads began without start")

endmodule

`default_nettype wire

[hw/rtl/lwa_ctrl.sv]
// sequencer: config registers, item decode, run read order, bank swap, result register
// depends on lwa_pkg and the assertion macro header
`default_nettype none
`include "lax_wendroff_advection_stencil_defines.svh"

module lwa_ctrl (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output      logic                                  req_tready,
   input  wire logic [lwa_pkg::OPCODE_W-1:0]          req_opcode,
   input  wire logic [lwa_pkg::POINT_W-1:0]           req_point_index,
   input  wire logic signed [lwa_pkg::SAMPLE_W-1:0]   req_sample_value,
   input  wire logic [lwa_pkg::STEPS_W-1:0]           req_step_count,
   output      logic                                  rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output      logic signed [lwa_pkg::SAMPLE_W-1:0]   rsp_read_value,
   output      logic                                  rsp_status,
   input  wire logic                                  csr_we,
   input  wire logic [lwa_pkg::CSR_ADDR_W-1:0]        csr_addr,
   input  wire logic [lwa_pkg::CSR_DATA_W-1:0]        csr_wdata,
   output      logic [lwa_pkg::COEF_W-1:0]            half_courant,
   output      logic [lwa_pkg::COEF_W-1:0]            half_courant_sq,
   output      lwa_pkg::mem_req_type                  mreq,
   output      logic                                  bank,
   input  wire logic signed [lwa_pkg::SAMPLE_W-1:0]   cur_rdata,
   output      lwa_pkg::step_ctl_type                 step_ctl,
   input  wire logic                                  step_busy
);

   localparam int PT_W = lwa_pkg::PT_W;
   localparam int SW   = lwa_pkg::SAMPLE_W;

   lwa_pkg::ctrl_state_type          st_ff, st_in;
   logic [PT_W-1:0]                  k_ff, k_in;
   logic [lwa_pkg::STEPS_W-1:0]      steps_ff, steps_in;
   logic                             bank_ff, bank_in;
   logic signed [SW-1:0]             res_val_ff, res_val_in;
   logic                             res_st_ff, res_st_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic signed [SW-1:0]             rsp_value_ff, rsp_value_in;
   logic                             rsp_status_ff, rsp_status_in;
   logic [PT_W-1:0]                  points_ff, points_in;
   logic [lwa_pkg::COEF_W-1:0]       h_ff, h_in, g_ff, g_in;
   logic [lwa_pkg::GCFG_W-1:0]       gcfg;
   logic                             in_range;
   logic [lwa_pkg::IDX_W-1:0]        last_addr;

   // configuration, grid size clamped on write
   always_comb begin
      points_in = points_ff;
      h_in      = h_ff;
      g_in      = g_ff;
      gcfg      = csr_wdata[lwa_pkg::GCFG_W-1:0];
      if (csr_we) begin
         case (lwa_pkg::csr_index_type'(csr_addr))
            lwa_pkg::CSR_GRID_POINTS: begin
               if (32'(gcfg) < 32'(lwa_pkg::MIN_POINTS)) begin
                  points_in = PT_W'(lwa_pkg::MIN_POINTS);
               end else if (32'(gcfg) > 32'(lwa_pkg::MAX_POINTS)) begin
                  points_in = PT_W'(lwa_pkg::MAX_POINTS);
               end else begin
                  points_in = PT_W'(gcfg);
               end
            end
            lwa_pkg::CSR_HALF_COURANT: begin
               h_in = csr_wdata[lwa_pkg::COEF_W-1:0];
            end
            lwa_pkg::CSR_HALF_COURANT_SQ: begin
               g_in = csr_wdata[lwa_pkg::COEF_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      st_in         = st_ff;
      k_in          = k_ff;
      steps_in      = steps_ff;
      bank_in       = bank_ff;
      res_val_in    = res_val_ff;
      res_st_in     = res_st_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      mreq          = '0;
      step_ctl      = '0;
      req_tready    = 1'b0;
      in_range      = 32'(req_point_index) < 32'(points_ff);
      last_addr     = lwa_pkg::IDX_W'(points_ff - PT_W'(1));

      case (st_ff)
         lwa_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               res_val_in = '0;
               res_st_in  = lwa_pkg::STATUS_DONE;
               st_in      = lwa_pkg::ST_RESP;
               case (lwa_pkg::opcode_type'(req_opcode))
                  lwa_pkg::OP_LOAD: begin
                     if (in_range) begin
                        mreq.wr_en   = 1'b1;
                        mreq.wr_addr = lwa_pkg::IDX_W'(req_point_index);
                        mreq.wr_data = req_sample_value;
                     end else begin
                        res_st_in = lwa_pkg::STATUS_RANGE;
                     end
                  end
                  lwa_pkg::OP_READ: begin
                     if (in_range) begin
                        mreq.rd_en   = 1'b1;
                        mreq.rd_addr = lwa_pkg::IDX_W'(req_point_index);
                        st_in        = lwa_pkg::ST_RD_DATA;
                     end else begin
                        res_st_in = lwa_pkg::STATUS_RANGE;
                     end
                  end
                  lwa_pkg::OP_RUN: begin
                     if (req_step_count != '0) begin
                        steps_in = req_step_count;
                        k_in     = '0;
                        st_in    = lwa_pkg::ST_RUN_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         lwa_pkg::ST_RD_DATA: begin
            res_val_in = cur_rdata;
            st_in      = lwa_pkg::ST_RESP;
         end
         lwa_pkg::ST_RUN_RD: begin
            // read order: last point, 0 .. n-1, then point 0 again
            mreq.rd_en     = 1'b1;
            step_ctl.issue = 1'b1;
            step_ctl.start = k_ff == '0;
            if (k_ff == '0) begin
               mreq.rd_addr = last_addr;
            end else if (k_ff == PT_W'(points_ff + PT_W'(1))) begin
               mreq.rd_addr = '0;
            end else begin
               mreq.rd_addr = lwa_pkg::IDX_W'(k_ff - PT_W'(1));
            end
            k_in = k_ff + PT_W'(1);
            if (k_ff == PT_W'(points_ff + PT_W'(1))) begin
               st_in = lwa_pkg::ST_RUN_DRAIN;
            end
         end
         lwa_pkg::ST_RUN_DRAIN: begin
            // next step reads what this one wrote, so wait for the last write
            if (!step_busy) begin
               bank_in  = !bank_ff;
               steps_in = steps_ff - lwa_pkg::STEPS_W'(1);
               k_in     = '0;
               if (steps_ff == lwa_pkg::STEPS_W'(1)) begin
                  st_in = lwa_pkg::ST_RESP;
               end else begin
                  st_in = lwa_pkg::ST_RUN_RD;
               end
            end
         end
         lwa_pkg::ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = res_val_ff;
               rsp_status_in = res_st_ff;
               st_in         = lwa_pkg::ST_IDLE;
            end
         end
         default: begin
            st_in = lwa_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= lwa_pkg::ST_IDLE;
         bank_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         points_ff    <= PT_W'(lwa_pkg::MAX_POINTS);
         h_ff         <= '0;
         g_ff         <= '0;
         k_ff         <= '0;
         steps_ff     <= '0;
      end else begin
         st_ff        <= st_in;
         bank_ff      <= bank_in;
         rsp_valid_ff <= rsp_valid_in;
         points_ff    <= points_in;
         h_ff         <= h_in;
         g_ff         <= g_in;
         k_ff         <= k_in;
         steps_ff     <= steps_in;
      end
   end

   always_ff @(posedge clock) begin
      res_val_ff    <= res_val_in;
      res_st_ff     <= res_st_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_read_value  = rsp_value_ff;
   assign rsp_status      = rsp_status_ff;
   assign half_courant    = h_ff;
   assign half_courant_sq = g_ff;
   assign bank            = bank_ff;

   `LWA_ASSERT_NEXT(a_one_item_at_a_time, req_tvalid && req_tready, !req_tready,
                    "item taken while another is in progress")
   `LWA_ASSERT_NEXT(a_bank_held_while_draining,
                    st_ff == lwa_pkg::ST_RUN_DRAIN && step_busy, $stable(bank_ff),
                    "banks swapped before the last write of a step")
   `LWA_ASSERT_SAME(a_run_addr_in_grid, st_ff == lwa_pkg::ST_RUN_RD,
                    32'(mreq.rd_addr) < 32'(points_ff), "run read beyond grid")
   `LWA_ASSERT_SAME(a_steps_left,
                    st_ff == lwa_pkg::ST_RUN_RD || st_ff == lwa_pkg::ST_RUN_DRAIN,
                    steps_ff != '0, "run active with no steps left")

endmodule

`default_nettype wire

[hw/rtl/lax_wendroff_advection_stencil.sv]
// Lax-Wendroff stencil for 1-D periodic linear advection, two-bank grid storage.
// Input channel req_*: one item per handshake, packed in req_tdata: load (write a
// sample of the current bank), run (advance step_count time steps), read (return
// a sample). Result channel rsp_*: exactly one item per input item, in order.
// Config port csr_*: grid_points, half_courant, half_courant_sq, written when idle.
// Items are handled one at a time. A load, an out-of-range index, a zero-step run
// or an unused opcode passes from acceptance through ST_RESP to the rsp register;
// a read passes through ST_RD_DATA first. Each run step streams N+2 reads for N
// points through the single read port of the current bank (one sample a cycle),
// then waits for the stencil pipeline to write the last point into the other
// bank before the banks swap.
// The next item can be accepted once the previous result is handed to the rsp
// register, even while that result still waits for rsp_tready.
// Reset (synchronous, active high) makes bank a current and restores the register
// defaults; grid contents are undefined until loaded. A stall on rsp_tready only
// holds the result and, once a second result is ready, the sequencer.
`default_nettype none

module lax_wendroff_advection_stencil (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output      logic                              req_tready,
   // opcode[1:0], point_index[11:2], sample_value[27:12], step_count[43:28]
   input  wire logic [lwa_pkg::REQ_W-1:0]         req_tdata,
   output      logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   // read_value[15:0], status[16]
   output      logic [lwa_pkg::RSP_W-1:0]         rsp_tdata,
   input  wire logic                              csr_we,
   input  wire logic [lwa_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire logic [lwa_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int SW = lwa_pkg::SAMPLE_W;

   logic signed [SW-1:0]         rsp_value;
   logic                         rsp_status;
   logic [lwa_pkg::COEF_W-1:0]   h, g;
   lwa_pkg::mem_req_type         mreq;
   lwa_pkg::step_ctl_type        step_ctl;
   lwa_pkg::step_wr_type         step_wr;
   logic                         bank, step_busy;
   logic signed [SW-1:0]         cur_rdata;
   logic [SW-1:0]                a_rdata, b_rdata;
   logic                         a_we, b_we, a_re, b_re;
   logic [lwa_pkg::IDX_W-1:0]    a_waddr, b_waddr;
   logic [SW-1:0]                a_wdata, b_wdata;

   lwa_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_opcode       (req_tdata[1:0]),
      .req_point_index  (req_tdata[11:2]),
      .req_sample_value ($signed(req_tdata[27:12])),
      .req_step_count   (req_tdata[43:28]),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_read_value   (rsp_value),
      .rsp_status       (rsp_status),
      .csr_we           (csr_we),
      .csr_addr         (csr_addr),
      .csr_wdata        (csr_wdata),
      .half_courant     (h),
      .half_courant_sq  (g),
      .mreq             (mreq),
      .bank             (bank),
      .cur_rdata        (cur_rdata),
      .step_ctl         (step_ctl),
      .step_busy        (step_busy)
   );

   lwa_step_unit u_step (
      .clock           (clock),
      .reset           (reset),
      .ctl             (step_ctl),
      .rdata           (cur_rdata),
      .half_courant    (h),
      .half_courant_sq (g),
      .wr              (step_wr),
      .busy            (step_busy)
   );

   // reads and loads go to the current bank, stencil writes to the other one
   always_comb begin
      a_re    = mreq.rd_en && !bank;
      b_re    = mreq.rd_en && bank;
      a_we    = (mreq.wr_en && !bank) || (step_wr.we && bank);
      b_we    = (mreq.wr_en && bank) || (step_wr.we && !bank);
      a_waddr = mreq.wr_en ? mreq.wr_addr : step_wr.addr;
      b_waddr = a_waddr;
      a_wdata = mreq.wr_en ? mreq.wr_data : step_wr.data;
      b_wdata = a_wdata;
      cur_rdata = bank ? $signed(b_rdata) : $signed(a_rdata);
   end

   lwa_ram #(
      .WIDTH (SW),
      .DEPTH (lwa_pkg::MAX_POINTS)
   ) u_bank_a (
      .clock (clock),
      .we    (a_we),
      .waddr (a_waddr),
      .wdata (a_wdata),
      .re    (a_re),
      .raddr (mreq.rd_addr),
      .rdata (a_rdata)
   );

   lwa_ram #(
      .WIDTH (SW),
      .DEPTH (lwa_pkg::MAX_POINTS)
   ) u_bank_b (
      .clock (clock),
      .we    (b_we),
      .waddr (b_waddr),
      .wdata (b_wdata),
      .re    (b_re),
      .raddr (mreq.rd_addr),
      .rdata (b_rdata)
   );

   assign rsp_tdata = {(lwa_pkg::RSP_W - SW - 1)'(0), rsp_status, rsp_value};

endmodule

`default_nettype wire

[tb/testbench.sv]
// self-checking testbench for the lax-wendroff advection stencil: loads, reads and
// multi-step runs on the periodic grid, checked against an in-file shadow of the grid.
// depends on lwa_pkg and the lax_wendroff_advection_stencil rtl only
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int OPCODE_W   = lwa_pkg::OPCODE_W;
   localparam int POINT_W    = lwa_pkg::POINT_W;
   localparam int SAMPLE_W   = lwa_pkg::SAMPLE_W;
   localparam int STEPS_W    = lwa_pkg::STEPS_W;
   localparam int COEF_W     = lwa_pkg::COEF_W;
   localparam int GCFG_W     = lwa_pkg::GCFG_W;
   localparam int CSR_ADDR_W = lwa_pkg::CSR_ADDR_W;
   localparam int CSR_DATA_W = lwa_pkg::CSR_DATA_W;
   localparam int REQ_W      = lwa_pkg::REQ_W;
   localparam int RSP_W      = lwa_pkg::RSP_W;
   localparam int MAX_POINTS = lwa_pkg::MAX_POINTS;
   localparam int MIN_POINTS = lwa_pkg::MIN_POINTS;

   localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
   localparam int LONG_HOLD  = 400;
   localparam int HOLD_AFTER = 150;

   typedef struct {
      logic [OPCODE_W-1:0] op;
      logic [POINT_W-1:0]  idx;
      logic [SAMPLE_W-1:0] sample;
      logic [STEPS_W-1:0]  steps;
      bit                  wait_drain;
   } stencil_item_type;

   typedef struct {
      logic signed [SAMPLE_W-1:0] value;
      logic                       status;
   } stencil_reply_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // opcode[1:0], point_index[11:2], sample_value[27:12], step_count[43:28]
   logic [REQ_W-1:0]      req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // read_value[15:0], status[16]
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   lax_wendroff_advection_stencil uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // shadow of the grid, advanced as items are accepted
   logic signed [SAMPLE_W-1:0] grid_copy [0:1][0:MAX_POINTS-1];
   bit                         grid_side = 1'b0;
   int                         cfg_points = MAX_POINTS;
   longint                     cfg_h = 0;
   longint                     cfg_g = 0;
   stencil_reply_type          owed_replies [$];

   // which entries will hold a written sample once the queued items are done
   bit                         plan_written [0:1][0:MAX_POINTS-1];
   bit                         plan_side = 1'b0;
   int                         plan_n = MAX_POINTS;
   bit                         drain_next = 1'b0;
   stencil_item_type           pending_items [$];

   bit                         offering = 1'b0;
   stencil_item_type           on_bus;
   int                         gap_left = 0;
   bit                         calm = 1'b0;
   int                         replies_seen = 0;
   int                         errors = 0;

   function automatic int points_in_grid(int raw);
      if (raw < MIN_POINTS) return MIN_POINTS;
      if (raw > MAX_POINTS) return MAX_POINTS;
      return raw;
   endfunction

   // nearest, ties toward plus infinity
   function automatic longint round_q16(longint p);
      if (p >= 0) return (p + 32768) >>> 16;
      return -((-p + 32767) >>> 16);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] clamp_sample(longint v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return SAMPLE_W'(v);
   endfunction

   function automatic void advance_grid(int n);
      longint up, uc, um, acc;
      int     ip, im;
      for (int i = 0; i < n; i++) begin
         ip  = (i + 1 == n) ? 0 : i + 1;
         im  = (i == 0) ? n - 1 : i - 1;
         up  = grid_copy[grid_side][ip];
         uc  = grid_copy[grid_side][i];
         um  = grid_copy[grid_side][im];
         acc = uc - round_q16(cfg_h * (up - um)) + round_q16(cfg_g * (up - 2 * uc + um));
         grid_copy[!grid_side][i] = clamp_sample(acc);
      end
      grid_side = !grid_side;
   endfunction

   function automatic void predict_reply(stencil_item_type it);
      stencil_reply_type r;
      int                n;
      r.value  = '0;
      r.status = lwa_pkg::STATUS_DONE;
      n = points_in_grid(cfg_points);
      if (it.op == lwa_pkg::OP_LOAD || it.op == lwa_pkg::OP_READ) begin
         if (it.idx >= n) r.status = lwa_pkg::STATUS_RANGE;
         else if (it.op == lwa_pkg::OP_LOAD) grid_copy[grid_side][it.idx] = it.sample;
         else r.value = grid_copy[grid_side][it.idx];
      end else if (it.op == lwa_pkg::OP_RUN) begin
         for (int s = 0; s < it.steps; s++) advance_grid(n);
      end
      owed_replies = {owed_replies, r};
   endfunction

   function automatic void push_item(stencil_item_type it);
      it.wait_drain = drain_next;
      drain_next = 1'b0;
      if (it.op == lwa_pkg::OP_LOAD && it.idx < plan_n) plan_written[plan_side][it.idx] = 1'b1;
      if (it.op == lwa_pkg::OP_RUN && it.steps != 0) begin
         // first step fills the other bank, the second one this bank
         for (int s = 0; s < 2 && s < it.steps; s++)
            for (int i = 0; i < plan_n; i++)
               plan_written[(s == 0) ? !plan_side : plan_side][i] = 1'b1;
         plan_side ^= it.steps[0];
      end
      pending_items = {pending_items, it};
   endfunction

   // unused fields carry random bits
   function automatic stencil_item_type random_item(logic [OPCODE_W-1:0] op);
      stencil_item_type it;
      it.op         = op;
      it.idx        = POINT_W'($urandom);
      it.sample     = SAMPLE_W'($urandom);
      it.steps      = STEPS_W'($urandom);
      it.wait_drain = 1'b0;
      return it;
   endfunction

   function automatic logic [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(0, 7))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic void queue_load(int idx, logic [SAMPLE_W-1:0] v);
      stencil_item_type it;
      it = random_item(lwa_pkg::OP_LOAD);
      it.idx = POINT_W'(idx);
      it.sample = v;
      push_item(it);
   endfunction

   function automatic void queue_read(int idx);
      stencil_item_type it;
      it = random_item(lwa_pkg::OP_READ);
      it.idx = POINT_W'(idx);
      push_item(it);
   endfunction

   function automatic void fill_grid();
      for (int i = 0; i < plan_n; i++)
         if (!plan_written[plan_side][i]) queue_load(i, random_sample());
   endfunction

   // a run only goes out once every point it touches holds a sample
   function automatic void queue_run(int steps);
      stencil_item_type it;
      if (steps != 0) fill_grid();
      it = random_item(lwa_pkg::OP_RUN);
      it.steps = STEPS_W'(steps);
      push_item(it);
   endfunction

   // max_steps of zero keeps every run at zero steps
   function automatic void queue_random(int max_steps);
      stencil_item_type it;
      int               pick, idx, steps_pick;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         idx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAX_POINTS - 1)
                                            : $urandom_range(0, plan_n - 1);
         queue_load(idx, random_sample());
      end else if (pick < 65) begin
         idx = $urandom_range(0, plan_n - 1);
         if (plan_written[plan_side][idx]) queue_read(idx);
         else queue_load(idx, random_sample());
      end else if (pick < 85) begin
         steps_pick = $urandom_range(0, 9);
         queue_run((steps_pick == 0 || max_steps == 0) ? 0 :
                   steps_pick < 3 ? 1 : $urandom_range(1, max_steps));
      end else if (pick < 92 || plan_n == MAX_POINTS) begin
         push_item(random_item(OP_UNUSED));
      end else begin
         it = random_item($urandom_range(0, 1) ? lwa_pkg::OP_LOAD : lwa_pkg::OP_READ);
         it.idx = POINT_W'($urandom_range(plan_n, MAX_POINTS - 1));
         push_item(it);
      end
   endfunction

   task automatic wait_idle();
      while (pending_items.size() != 0 || offering || owed_replies.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(lwa_pkg::csr_index_type which, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= which;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      case (which)
         lwa_pkg::CSR_GRID_POINTS: begin
            cfg_points = value[GCFG_W-1:0];
            plan_n     = points_in_grid(value[GCFG_W-1:0]);
         end
         lwa_pkg::CSR_HALF_COURANT:    cfg_h = value;
         lwa_pkg::CSR_HALF_COURANT_SQ: cfg_g = value;
         default: ;
      endcase
   endtask

   task automatic start_phase(logic [GCFG_W-1:0] pts, logic [COEF_W-1:0] h,
                              logic [COEF_W-1:0] g);
      logic [CSR_DATA_W-GCFG_W-1:0] junk;
      junk = (CSR_DATA_W-GCFG_W)'($urandom);
      wait_idle();
      write_reg(lwa_pkg::CSR_GRID_POINTS, {junk, pts});
      write_reg(lwa_pkg::CSR_HALF_COURANT, h);
      write_reg(lwa_pkg::CSR_HALF_COURANT_SQ, g);
   endtask

   task automatic random_phase(logic [GCFG_W-1:0] pts, logic [COEF_W-1:0] h,
                               logic [COEF_W-1:0] g, int count, int max_steps, bit force_drain);
      start_phase(pts, h, g);
      if (max_steps != 0) fill_grid();
      for (int k = 0; k < count; k++) begin
         if ((force_drain && k == count / 2) || $urandom_range(0, 32) == 0) drain_next = 1'b1;
         queue_random(max_steps);
      end
   endtask

   // stable coefficients: h = c/2, g = c*c/2 for a courant number c in [0, 1]
   task automatic pick_courant(output logic [COEF_W-1:0] h, output logic [COEF_W-1:0] g);
      longint c;
      c = $urandom_range(0, 65536);
      h = COEF_W'(c >> 1);
      g = COEF_W'((c * c) >> 17);
   endtask

   initial begin
      logic [COEF_W-1:0] h, g;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // register defaults: full grid, zero coefficients
      push_item(random_item(OP_UNUSED));
      queue_run(0);
      queue_load(MAX_POINTS - 1, 16'h8000);
      queue_read(MAX_POINTS - 1);
      queue_load(0, 16'h7FFF);
      queue_read(0);

      // grid size below the minimum, coefficients at full scale
      start_phase(11'd0, 16'hFFFF, 16'hFFFF);
      queue_load(0, 16'h7FFF);
      queue_load(1, 16'h8000);
      queue_load(2, 16'h0001);
      queue_load(3, 16'h1234);
      queue_read(3);
      queue_read(MAX_POINTS - 1);
      queue_read(0);
      queue_read(1);
      queue_run(1);
      queue_read(0);
      queue_read(1);
      queue_read(2);
      queue_run(2);
      queue_read(2);
      queue_load(2, 16'hFFFF);
      queue_run(0);
      queue_read(2);
      push_item(random_item(OP_UNUSED));

      pick_courant(h, g);
      random_phase(11'd5, h, g, 50, 20, 1'b0);
      pick_courant(h, g);
      random_phase(11'd16, h, g, 50, 10, 1'b0);
      pick_courant(h, g);
      random_phase(11'd2047, h, g, 30, 0, 1'b0);
      random_phase(11'd64, 16'h8000, 16'h8000, 50, 8, 1'b1);
      random_phase(11'd1025, 16'h0000, 16'h0000, 25, 0, 1'b0);
      random_phase(11'd3, COEF_W'($urandom), COEF_W'($urandom), 50, 40, 1'b0);
      pick_courant(h, g);
      random_phase(11'd200, h, g, 40, 3, 1'b0);
      calm = 1'b1;
      pick_courant(h, g);
      random_phase(11'd7, h, g, 70, 30, 1'b0);

      wait_idle();
      if (errors == 0) begin
         $display("lax_wendroff_advection_stencil test passed");
      end else begin
         $display("lax_wendroff_advection_stencil test failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("lax_wendroff_advection_stencil test failed");
      $finish;
   end

   // item driver
   always @(negedge clock) begin
      if (!reset && !offering) begin
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_items.size() != 0 &&
                      !(pending_items[0].wait_drain && owed_replies.size() != 0)) begin
            on_bus   = pending_items.pop_front();
            offering = 1'b1;
            req_tdata <= REQ_W'({on_bus.steps, on_bus.sample, on_bus.idx, on_bus.op});
         end
         req_tvalid <= offering;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         predict_reply(on_bus);
         offering = 1'b0;
         if (!calm && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 11);
      end
   end

   // result ready: short random stalls plus one long hold to back up the input
   int  stall_left = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;

   always @(negedge clock) begin
      if (!reset) begin
         if (hold_left > 0) begin
            hold_left--;
         end else if (!hold_done && replies_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
         end else if (stall_left > 0) begin
            stall_left--;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 11);
         end
         rsp_tready <= (hold_left == 0 && stall_left == 0);
      end
   end

   always @(posedge clock) begin : reply_check
      stencil_reply_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         replies_seen++;
         if (owed_replies.size() == 0) begin
            errors++;
            $display("%0t: reply with nothing owed, expected none actual %h", $time, rsp_tdata);
         end else begin
            want = owed_replies.pop_front();
            if (rsp_tdata[SAMPLE_W-1:0] !== want.value) begin
               errors++;
               $display("%0t: read_value expected %0d actual %0d", $time, want.value,
                        $signed(rsp_tdata[SAMPLE_W-1:0]));
            end
            if (rsp_tdata[SAMPLE_W] !== want.status) begin
               errors++;
               $display("%0t: status expected %0b actual %b", $time, want.status,
                        rsp_tdata[SAMPLE_W]);
            end
            if (rsp_tdata[RSP_W-1:SAMPLE_W+1] !== '0) begin
               errors++;
               $display("%0t: padding expected 0 actual %h", $time,
                        rsp_tdata[RSP_W-1:SAMPLE_W+1]);
            end
         end
      end
   end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/lwa_pkg.sv
hw/rtl/lwa_ram.sv
hw/rtl/lwa_step_unit.sv
hw/rtl/lwa_ctrl.sv
hw/rtl/lax_wendroff_advection_stencil.sv
tb/testbench.sv
